@@ design/lbpfm_pkg.sv @@
// ---------------------------------------------------------------------------
// lbpfm_pkg
// Shared codes and types of the buffer pool frame manager.
// ---------------------------------------------------------------------------
package lbpfm_pkg;

  localparam int PAGE_W = 37;

  localparam logic [1:0] OP_FIX   = 2'd0;
  localparam logic [1:0] OP_UNFIX = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  localparam logic [2:0] RS_HIT        = 3'd0;
  localparam logic [2:0] RS_LOADED     = 3'd1;
  localparam logic [2:0] RS_NOT_PRES   = 3'd2;
  localparam logic [2:0] RS_ALL_PINNED = 3'd3;
  localparam logic [2:0] RS_UNFIXED    = 3'd4;
  localparam logic [2:0] RS_UNKNOWN    = 3'd5;
  localparam logic [2:0] RS_WRITE_BACK = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_DEC,
    S_WBR,
    S_WBD,
    S_EVICT,
    S_LOAD,
    S_FL_RD,
    S_FL_EM
  } state_t;

endpackage

@@ design/lbpfm_req_if.sv @@
// ---------------------------------------------------------------------------
// lbpfm_req_if
// Request channel: one word per page request.
// ---------------------------------------------------------------------------
interface lbpfm_req_if;
  import lbpfm_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [PAGE_W-1:0] page_id;
  logic              exclusive;
  logic              mark_dirty;
  logic              page_present;

  modport source (output valid, op, page_id, exclusive, mark_dirty, page_present,
                  input ready);
  modport sink (input valid, op, page_id, exclusive, mark_dirty, page_present,
                output ready);
endinterface

@@ design/lbpfm_res_if.sv @@
// ---------------------------------------------------------------------------
// lbpfm_res_if
// Result channel: one word per result of a request.
// ---------------------------------------------------------------------------
interface lbpfm_res_if;
  import lbpfm_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [3:0]        frame_index;
  logic [PAGE_W-1:0] result_page;
  logic              last;

  modport source (output valid, status, frame_index, result_page, last, input ready);
  modport sink (input valid, status, frame_index, result_page, last, output ready);
endinterface

@@ design/lbpfm_ram.sv @@
// ---------------------------------------------------------------------------
// lbpfm_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module lbpfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ design/lru_buffer_pool_frame_manager_unit.sv @@
// ---------------------------------------------------------------------------
// lru_buffer_pool_frame_manager_unit
// Fix and unfix scan the page RAM one frame at a time, reading each frame and
// then comparing it; flush scans the frames and emits one result per
// write-back. One request at a time; ready only when idle. The scan goes
// through the single read port of the page RAM.
// Reset clears valid, pin, dirty and write-mode marks; no clearing pass.
// ---------------------------------------------------------------------------
module lru_buffer_pool_frame_manager_unit
  import lbpfm_pkg::*;
#(
  parameter int FRAMES   = 16,
  parameter int PIN_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  lbpfm_req_if.sink   req,
  lbpfm_res_if.source res
);
  localparam int IW = $clog2(FRAMES);
  localparam int CW = $clog2(FRAMES + 1);

  state_t st, st_next;

  logic [CW-1:0]       idx;
  logic [IW-1:0]       ci;
  logic [1:0]          r_op;
  logic [PAGE_W-1:0]   r_page;
  logic                r_excl, r_mdirty, r_present;
  logic                hit_found, free_found, vic_found;
  logic [IW-1:0]       hit_f, free_f, vic_f;

  logic [FRAMES-1:0]   valid, dirty, writ, cand;
  logic [PIN_BITS-1:0] pins [FRAMES];
  logic [IW-1:0]       rank [FRAMES];

  logic                out_valid, out_free, out_set, idx_end, cand_above;
  logic [2:0]          out_status;
  logic [3:0]          out_frame;
  logic [PAGE_W-1:0]   out_page;
  logic                out_last;

  logic                ram_we;
  logic [IW-1:0]       ram_raddr;
  logic [PAGE_W-1:0]   ram_rdata;

  localparam logic [PIN_BITS-1:0] PinMax = {PIN_BITS{1'b1}};

  assign ci         = idx[IW-1:0];
  assign cand       = valid & dirty & writ;
  assign out_free   = !out_valid || res.ready;
  assign idx_end    = (idx == CW'(FRAMES - 1));
  assign cand_above = ((cand >> ci) >> 1) != '0;

  assign req.ready       = (st == S_IDLE);
  assign res.valid       = out_valid;
  assign res.status      = out_status;
  assign res.frame_index = out_frame;
  assign res.result_page = out_page;
  assign res.last        = out_last;

  always_comb begin
    case (st)
      S_WBR, S_WBD: ram_raddr = vic_f;
      default:      ram_raddr = ci;
    endcase
  end

  // A new result word is loaded into the output register in these states.
  always_comb begin
    case (st)
      S_DEC:   out_set = out_free &&
                         (r_op == OP_UNFIX || hit_found || (!free_found && !vic_found));
      S_WBD, S_LOAD, S_FL_EM: out_set = out_free;
      default: out_set = 1'b0;
    endcase
  end

  assign ram_we = (st == S_LOAD) && out_free && r_present;

  lbpfm_ram #(.WIDTH(PAGE_W), .DEPTH(FRAMES)) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_f),
    .wdata (r_page),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    st_next = st;
    case (st)
      S_IDLE: begin
        if (req.valid) begin
          if (req.op == OP_FIX || req.op == OP_UNFIX) begin
            st_next = S_RD;
          end else if (req.op == OP_FLUSH) begin
            st_next = S_FL_RD;
          end
        end
      end
      S_RD:  st_next = S_CMP;
      S_CMP: st_next = idx_end ? S_DEC : S_RD;
      S_DEC: begin
        if (r_op == OP_UNFIX || hit_found) begin
          if (out_free) st_next = S_IDLE;
        end else if (free_found) begin
          st_next = S_LOAD;
        end else if (!vic_found) begin
          if (out_free) st_next = S_IDLE;
        end else if (dirty[vic_f] && writ[vic_f]) begin
          st_next = S_WBR;
        end else begin
          st_next = S_EVICT;
        end
      end
      S_WBR: st_next = S_WBD;
      S_WBD: if (out_free) st_next = S_EVICT;
      S_EVICT: st_next = S_LOAD;
      S_LOAD: if (out_free) st_next = S_IDLE;
      S_FL_RD: begin
        if (idx == CW'(FRAMES)) begin
          st_next = S_IDLE;
        end else if (cand[ci]) begin
          st_next = S_FL_EM;
        end
      end
      S_FL_EM: if (out_free) st_next = S_FL_RD;
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      out_valid <= 1'b0;
      valid     <= '0;
      dirty     <= '0;
      writ      <= '0;
      for (int i = 0; i < FRAMES; i++) pins[i] <= '0;
    end else begin
      st <= st_next;
      out_valid <= out_set || (out_valid && !res.ready);
      case (st)
        S_IDLE: begin
          r_op       <= req.op;
          r_page     <= req.page_id;
          r_excl     <= req.exclusive;
          r_mdirty   <= req.mark_dirty;
          r_present  <= req.page_present;
          idx        <= '0;
          hit_found  <= 1'b0;
          free_found <= 1'b0;
          vic_found  <= 1'b0;
        end
        S_CMP: begin
          if (valid[ci] && ram_rdata == r_page && !hit_found) begin
            hit_found <= 1'b1;
            hit_f     <= ci;
          end
          if (!valid[ci] && !free_found) begin
            free_found <= 1'b1;
            free_f     <= ci;
          end
          if (valid[ci] && pins[ci] == '0 && (!vic_found || rank[ci] > rank[vic_f])) begin
            vic_found <= 1'b1;
            vic_f     <= ci;
          end
          idx <= idx + 1'b1;
        end
        S_DEC: begin
          if (out_free) begin
            if (r_op == OP_UNFIX) begin
              out_page  <= r_page;
              out_last  <= 1'b1;
              if (hit_found) begin
                if (pins[hit_f] != '0) pins[hit_f] <= pins[hit_f] - 1'b1;
                if (r_mdirty) dirty[hit_f] <= 1'b1;
                out_status <= RS_UNFIXED;
                out_frame  <= 4'(hit_f);
              end else begin
                out_status <= RS_UNKNOWN;
                out_frame  <= '0;
              end
            end else if (hit_found) begin
              if (pins[hit_f] != PinMax) pins[hit_f] <= pins[hit_f] + 1'b1;
              writ[hit_f] <= writ[hit_f] | r_excl;
              for (int i = 0; i < FRAMES; i++) begin
                if (valid[i] && IW'(i) != hit_f && rank[i] < rank[hit_f]) begin
                  rank[i] <= rank[i] + 1'b1;
                end
              end
              rank[hit_f] <= '0;
              out_status <= RS_HIT;
              out_frame  <= 4'(hit_f);
              out_page   <= r_page;
              out_last   <= 1'b1;
            end else if (!free_found && !vic_found) begin
              out_status <= RS_ALL_PINNED;
              out_frame  <= '0;
              out_page   <= r_page;
              out_last   <= 1'b1;
            end
          end
        end
        S_WBD: begin
          if (out_free) begin
            out_status <= RS_WRITE_BACK;
            out_frame  <= 4'(vic_f);
            out_page   <= ram_rdata;
            out_last   <= 1'b0;
          end
        end
        S_EVICT: begin
          for (int i = 0; i < FRAMES; i++) begin
            if (valid[i] && rank[i] > rank[vic_f]) rank[i] <= rank[i] - 1'b1;
          end
          valid[vic_f] <= 1'b0;
          dirty[vic_f] <= 1'b0;
          writ[vic_f]  <= 1'b0;
          pins[vic_f]  <= '0;
          free_f       <= vic_f;
        end
        S_LOAD: begin
          if (out_free) begin
            out_page  <= r_page;
            out_last  <= 1'b1;
            if (r_present) begin
              for (int i = 0; i < FRAMES; i++) begin
                if (valid[i]) rank[i] <= rank[i] + 1'b1;
              end
              rank[free_f]  <= '0;
              valid[free_f] <= 1'b1;
              pins[free_f]  <= PIN_BITS'(1);
              dirty[free_f] <= 1'b0;
              writ[free_f]  <= r_excl;
              out_status    <= RS_LOADED;
              out_frame     <= 4'(free_f);
            end else begin
              out_status <= RS_NOT_PRES;
              out_frame  <= '0;
            end
          end
        end
        S_FL_RD: begin
          // A frame with nothing to write back is skipped.
          if (idx != CW'(FRAMES) && !cand[ci]) idx <= idx + 1'b1;
        end
        S_FL_EM: begin
          if (out_free) begin
            out_status <= RS_WRITE_BACK;
            out_frame  <= 4'(ci);
            out_page   <= ram_rdata;
            out_last   <= !cand_above;
            dirty[ci]  <= 1'b0;
            idx        <= idx + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
